@@ rtl/huffman_tree_walk_decoder_top_macros.svh @@
// assertion helpers for the tree walk decoder
`ifndef HUFFMAN_TREE_WALK_DECODER_TOP_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define HTWD_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define HTWD_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`else
`define HTWD_ASSERT(lbl, expr, msg)
`define HTWD_ASSERT_IMP(lbl, pre, post, msg)
`endif

`endif

@@ rtl/htwd_pkg.sv @@
`default_nettype none
package htwd_pkg;

  localparam int IdxW        = 9;
  localparam int SymW        = 8;
  localparam int CountW      = 32;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 32;
  localparam int BitsPerByte = 8;
  localparam int BitCntW     = $clog2(BitsPerByte + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROOT_INDEX   = 1'b0,
    CFG_SYMBOL_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_BYTE = 1'b1
  } kind_e;

  typedef struct packed {
    logic            leaf;
    logic [SymW-1:0] sym;
    logic [IdxW-1:0] child0;
    logic [IdxW-1:0] child1;
  } node_t;

endpackage
`default_nettype wire

@@ rtl/huffman_tree_walk_decoder_top.sv @@
`default_nettype none
`include "huffman_tree_walk_decoder_top_macros.svh"
// Tree walk decoder: load items (kind 0) write one node of the table and restart the
// message; byte items (kind 1) are walked least significant bit first, one table read
// per bit through the registered read port. For a byte the decoder takes the byte, makes
// eight reads, tests the last read and hands over the final symbol; the walk ends early
// when the configured symbol count is reached, and a byte that comes when the count is
// already met is taken with no walk. The walk stalls while the result side holds off a
// symbol. Each read address comes from the chain read data -> child select -> read address.
// A decoded symbol is held back so that last can be marked on the byte's final
// symbol. The table needs no clearing pass; entries must be written before a walk uses them.
module huffman_tree_walk_decoder_top #(
  parameter int NODE_COUNT = 512
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire                                 kind_i,
  input  wire  [htwd_pkg::IdxW-1:0]           node_index_i,
  input  wire                                 node_is_leaf_i,
  input  wire  [htwd_pkg::SymW-1:0]           node_symbol_i,
  input  wire  [htwd_pkg::IdxW-1:0]           zero_child_i,
  input  wire  [htwd_pkg::IdxW-1:0]           one_child_i,
  input  wire  [htwd_pkg::SymW-1:0]           code_byte_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [htwd_pkg::SymW-1:0]           symbol_o,
  output logic                                last_o,
  output logic                                finished_o,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [htwd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire  [htwd_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int AddrW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e                           state_q;
  logic [htwd_pkg::IdxW-1:0]        root_index_q;
  logic [htwd_pkg::CountW-1:0]      symbol_count_q;
  logic [htwd_pkg::CountW-1:0]      emitted_q;
  logic                             cur_root_q;
  logic                             pend_q;
  logic [htwd_pkg::SymW-1:0]        shift_q;
  logic [htwd_pkg::BitCntW-1:0]     bits_left_q;
  logic                             hold_valid_q;
  logic [htwd_pkg::SymW-1:0]        hold_sym_q;
  logic                             hold_fin_q;
  logic                             out_valid_q;
  logic [htwd_pkg::SymW-1:0]        symbol_q;
  logic                             last_q;
  logic                             finished_q;

  htwd_pkg::node_t                  mem_q [NODE_COUNT];
  htwd_pkg::node_t                  rd_q;
  htwd_pkg::node_t                  root_q;
  htwd_pkg::node_t                  wr_node;
  htwd_pkg::node_t                  cur_node;

  logic                             in_fire;
  logic                             cfg_fire;
  logic                             root_snap;
  logic                             wr_en;
  logic                             walking;
  logic                             leaf_hit;
  logic                             cur_root_n;
  logic [htwd_pkg::CountW-1:0]      emitted_inc;
  logic                             finish_hit;
  logic [htwd_pkg::BitCntW-1:0]     bits_n;
  logic                             issue;
  logic                             flush;
  logic                             push_mid;
  logic                             push_end;
  logic                             out_free;
  logic                             stall;
  logic                             step;
  logic                             rd_en;
  logic                             rd_load;
  logic [htwd_pkg::IdxW-1:0]        rd_idx;
  logic [htwd_pkg::IdxW-1:0]        rd_addr;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign wr_en       = in_fire && (htwd_pkg::kind_e'(kind_i) == htwd_pkg::KIND_LOAD) &&
                       (int'(node_index_i) < NODE_COUNT);

  // a new root_index leaves the walk on the old root node
  assign root_snap   = cfg_fire &&
                       (htwd_pkg::cfg_reg_e'(cfg_index_i) == htwd_pkg::CFG_ROOT_INDEX) &&
                       cur_root_q && (state_q == ST_IDLE) && !in_fire;

  assign wr_node.leaf   = node_is_leaf_i;
  assign wr_node.sym    = node_symbol_i;
  assign wr_node.child0 = zero_child_i;
  assign wr_node.child1 = one_child_i;

  assign walking     = (state_q == ST_WALK);
  // the last read returns the node the bit moved to
  assign leaf_hit    = walking && pend_q && rd_q.leaf;
  assign cur_root_n  = leaf_hit || (!pend_q && cur_root_q);
  assign cur_node    = cur_root_n ? root_q : rd_q;
  assign emitted_inc = emitted_q + htwd_pkg::CountW'(1);
  assign finish_hit  = leaf_hit && (emitted_inc == symbol_count_q);
  assign bits_n      = finish_hit ? '0 : bits_left_q;
  assign issue       = walking && (bits_n != '0);
  assign flush       = walking && !pend_q && (bits_left_q == '0);
  assign push_mid    = leaf_hit && hold_valid_q;
  assign push_end    = flush && hold_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign stall       = (push_mid || push_end) && !out_free;
  assign step        = walking && !stall;
  assign rd_en       = issue && !stall;
  assign rd_idx      = shift_q[0] ? cur_node.child1 : cur_node.child0;
  assign rd_load     = rd_en || root_snap;
  assign rd_addr     = rd_en ? rd_idx : root_index_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AddrW'(node_index_i)] <= wr_node;
    end
  end

  // walk port, out of range reads as a blank inner node
  always_ff @(posedge clk_i) begin
    if (rd_load) begin
      if (int'(rd_addr) < NODE_COUNT) begin
        rd_q <= mem_q[AddrW'(rd_addr)];
      end else begin
        rd_q <= '0;
      end
    end
  end

  // root port follows root_index every cycle
  always_ff @(posedge clk_i) begin
    if (int'(root_index_q) < NODE_COUNT) begin
      root_q <= mem_q[AddrW'(root_index_q)];
    end else begin
      root_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      root_index_q   <= '0;
      symbol_count_q <= '0;
      emitted_q      <= '0;
      cur_root_q     <= 1'b1;
      pend_q         <= 1'b0;
      bits_left_q    <= '0;
      hold_valid_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (htwd_pkg::cfg_reg_e'(cfg_index_i))
          htwd_pkg::CFG_ROOT_INDEX:   root_index_q   <= cfg_data_i[htwd_pkg::IdxW-1:0];
          htwd_pkg::CFG_SYMBOL_COUNT: symbol_count_q <= cfg_data_i[htwd_pkg::CountW-1:0];
          default: ;
        endcase
      end
      if (root_snap) begin
        cur_root_q <= 1'b0;
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (htwd_pkg::kind_e'(kind_i) == htwd_pkg::KIND_LOAD) begin
              cur_root_q <= 1'b1;
              emitted_q  <= '0;
            end else if (emitted_q < symbol_count_q) begin
              state_q      <= ST_WALK;
              shift_q      <= code_byte_i;
              bits_left_q  <= htwd_pkg::BitCntW'(htwd_pkg::BitsPerByte);
              pend_q       <= 1'b0;
              hold_valid_q <= 1'b0;
            end
          end
        end
        ST_WALK: begin
          if (step) begin
            cur_root_q <= cur_root_n;
            pend_q     <= issue;
            if (issue) begin
              shift_q     <= shift_q >> 1;
              bits_left_q <= bits_n - htwd_pkg::BitCntW'(1);
            end else begin
              bits_left_q <= bits_n;
            end
            // previous symbol is now known not to be the byte's final one
            if (push_mid) begin
              out_valid_q <= 1'b1;
              symbol_q    <= hold_sym_q;
              last_q      <= 1'b0;
              finished_q  <= hold_fin_q;
            end
            if (leaf_hit) begin
              emitted_q    <= emitted_inc;
              hold_valid_q <= 1'b1;
              hold_sym_q   <= rd_q.sym;
              hold_fin_q   <= finish_hit;
            end
            if (flush) begin
              if (hold_valid_q) begin
                out_valid_q <= 1'b1;
                symbol_q    <= hold_sym_q;
                last_q      <= 1'b1;
                finished_q  <= hold_fin_q;
              end
              hold_valid_q <= 1'b0;
              state_q      <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;
  assign finished_o  = finished_q;

  `HTWD_ASSERT(a_idle_no_hold, !((state_q == ST_IDLE) && hold_valid_q), "held symbol in idle")
  `HTWD_ASSERT_IMP(a_pend_walk, pend_q, state_q == ST_WALK, "read pending outside walk")
  `HTWD_ASSERT_IMP(a_fin_last, out_valid_q && finished_q, last_q, "finishing item not last")
  `HTWD_ASSERT_IMP(a_count_bound, state_q == ST_WALK, emitted_q <= symbol_count_q,
                   "emitted count beyond symbol count")

endmodule
`default_nettype wire

@@ tb/tb_huffman_tree_walk_decoder_top.sv @@
`default_nettype none
module tb_huffman_tree_walk_decoder_top;

  typedef struct packed {
    logic [htwd_pkg::SymW-1:0] sym;
    logic                      last;
    logic                      finished;
  } symbol_res_t;

  class decode_scoreboard;
    htwd_pkg::node_t             node_mem [512];
    logic [htwd_pkg::IdxW-1:0]   cur_node;
    logic [htwd_pkg::IdxW-1:0]   root_idx;
    logic [htwd_pkg::CountW-1:0] emitted;
    logic [htwd_pkg::CountW-1:0] sym_limit;
    symbol_res_t                 expected_syms [$];
    int                          mismatch_cnt;

    function void clear();
      foreach (node_mem[i]) node_mem[i] = '0;
      cur_node     = '0;
      root_idx     = '0;
      emitted      = '0;
      sym_limit    = '0;
      mismatch_cnt = 0;
      expected_syms.delete();
    endfunction

    function void write_reg(htwd_pkg::cfg_reg_e r, logic [htwd_pkg::CfgDataW-1:0] d);
      if (r == htwd_pkg::CFG_ROOT_INDEX) begin
        root_idx = d[htwd_pkg::IdxW-1:0];
      end else begin
        sym_limit = d;
      end
    endfunction

    // walk one byte through the node table, lsb first; a load item writes a node and restarts
    function void note_item(htwd_pkg::kind_e k, logic [htwd_pkg::IdxW-1:0] idx,
                            htwd_pkg::node_t nd, logic [htwd_pkg::SymW-1:0] code);
      symbol_res_t               batch [8];
      int                        n;
      logic [htwd_pkg::IdxW-1:0] nxt;
      n = 0;
      if (k == htwd_pkg::KIND_LOAD) begin
        node_mem[idx] = nd;
        cur_node = root_idx;
        emitted = '0;
        return;
      end
      if (emitted >= sym_limit) return;
      for (int b = 0; b < htwd_pkg::BitsPerByte; b++) begin
        nxt = code[b] ? node_mem[cur_node].child1 : node_mem[cur_node].child0;
        cur_node = nxt;
        if (node_mem[nxt].leaf) begin
          emitted++;
          batch[n].sym = node_mem[nxt].sym;
          batch[n].last = 1'b0;
          batch[n].finished = (emitted == sym_limit);
          n++;
          cur_node = root_idx;
          if (emitted == sym_limit) break;
        end
      end
      for (int i = 0; i < n; i++) begin
        if (i == n - 1) batch[i].last = 1'b1;
        expected_syms = {expected_syms, batch[i]};
      end
    endfunction

    function void check_symbol(logic [htwd_pkg::SymW-1:0] sym, logic last, logic fin);
      symbol_res_t exp_r;
      if (expected_syms.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected symbol %02h last %0b finished %0b", sym, last, fin);
        return;
      end
      exp_r = expected_syms.pop_front();
      if (exp_r.sym !== sym || exp_r.last !== last || exp_r.finished !== fin) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("symbol mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b (sym/last/finished)",
                   exp_r.sym, exp_r.last, exp_r.finished, sym, last, fin);
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic                            kind_i;
  logic [htwd_pkg::IdxW-1:0]       node_index_i;
  logic                            node_is_leaf_i;
  logic [htwd_pkg::SymW-1:0]       node_symbol_i;
  logic [htwd_pkg::IdxW-1:0]       zero_child_i;
  logic [htwd_pkg::IdxW-1:0]       one_child_i;
  logic [htwd_pkg::SymW-1:0]       code_byte_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [htwd_pkg::SymW-1:0]       symbol_o;
  logic                            last_o;
  logic                            finished_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [htwd_pkg::CfgIdxW-1:0]    cfg_index_i;
  logic [htwd_pkg::CfgDataW-1:0]   cfg_data_i;

  decode_scoreboard sb = new();

  logic [htwd_pkg::IdxW-1:0] tree_idx [16];
  logic                      tree_leaf [16];
  int                        tree_zero [16];
  int                        tree_one [16];
  int                        tree_size;
  int                        item_cnt;
  bit                        calm;
  bit                        hold_req;

  huffman_tree_walk_decoder_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .node_index_i   (node_index_i),
    .node_is_leaf_i (node_is_leaf_i),
    .node_symbol_i  (node_symbol_i),
    .zero_child_i   (zero_child_i),
    .one_child_i    (one_child_i),
    .code_byte_i    (code_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .symbol_o       (symbol_o),
    .last_o         (last_o),
    .finished_o     (finished_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        sb.write_reg(htwd_pkg::cfg_reg_e'(cfg_index_i), cfg_data_i);
      if (in_valid_i && in_ready_o)
        sb.note_item(htwd_pkg::kind_e'(kind_i), node_index_i,
                     htwd_pkg::node_t'{node_is_leaf_i, node_symbol_i, zero_child_i,
                                       one_child_i},
                     code_byte_i);
      if (out_valid_o && out_ready_i)
        sb.check_symbol(symbol_o, last_o, finished_o);
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int  mode_left;
    bit  mode_ready;
    int  hold_left;
    mode_left = 0;
    mode_ready = 1'b1;
    hold_left = 0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_ready = $urandom_range(0, 1) == 1;
          if (mode_ready) mode_left = $urandom_range(1, 20);
          else if ($urandom_range(0, 9) == 0) mode_left = $urandom_range(10, 40);
          else mode_left = $urandom_range(1, 3);
        end
        mode_left--;
        out_ready_i <= mode_ready;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 95) return int'($urandom_range(4, 10));
    return int'($urandom_range(20, 60));
  endfunction

  task automatic send_item(htwd_pkg::kind_e k, logic [htwd_pkg::IdxW-1:0] idx, logic lf,
                           logic [htwd_pkg::SymW-1:0] sy, logic [htwd_pkg::IdxW-1:0] z,
                           logic [htwd_pkg::IdxW-1:0] o, logic [htwd_pkg::SymW-1:0] cb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    node_index_i   <= idx;
    node_is_leaf_i <= lf;
    node_symbol_i  <= sy;
    zero_child_i   <= z;
    one_child_i    <= o;
    code_byte_i    <= cb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    item_cnt++;
  endtask

  task automatic load_node(logic [htwd_pkg::IdxW-1:0] idx, logic lf,
                           logic [htwd_pkg::SymW-1:0] sy,
                           logic [htwd_pkg::IdxW-1:0] z, logic [htwd_pkg::IdxW-1:0] o);
    send_item(htwd_pkg::KIND_LOAD, idx, lf, sy, z, o, htwd_pkg::SymW'($urandom));
  endtask

  task automatic send_byte(logic [htwd_pkg::SymW-1:0] cb);
    send_item(htwd_pkg::KIND_BYTE, htwd_pkg::IdxW'($urandom), 1'($urandom),
              htwd_pkg::SymW'($urandom), htwd_pkg::IdxW'($urandom),
              htwd_pkg::IdxW'($urandom), cb);
  endtask

  task automatic write_reg(htwd_pkg::cfg_reg_e r, logic [htwd_pkg::CfgDataW-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain all symbols, then give the walk time to finish a silent byte
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_syms.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  initial begin
    int                          msg;
    int                          leaves;
    int                          n;
    int                          p;
    int                          k;
    int                          j;
    int                          tmp;
    int                          r;
    int                          nbytes;
    int                          cand;
    bit                          dup;
    logic [htwd_pkg::CountW-1:0] lim;
    int                          order [16];

    sb.clear();
    item_cnt       = 0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = htwd_pkg::KIND_LOAD;
    node_index_i   = '0;
    node_is_leaf_i = 1'b0;
    node_symbol_i  = '0;
    zero_child_i   = '0;
    one_child_i    = '0;
    code_byte_i    = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = htwd_pkg::CFG_ROOT_INDEX;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // root at the top index with two leaves: every bit yields a symbol
    write_reg(htwd_pkg::CFG_ROOT_INDEX, 32'd511);
    write_reg(htwd_pkg::CFG_SYMBOL_COUNT, 32'hFFFF_FFFF);
    load_node(9'd511, 1'b0, 8'h5A, 9'd0, 9'd256);
    load_node(9'd0, 1'b1, 8'hFF, 9'd511, 9'd511);
    load_node(9'd256, 1'b1, 8'h00, 9'd0, 9'd511);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    // count lowered below what was already emitted
    settle();
    write_reg(htwd_pkg::CFG_SYMBOL_COUNT, 32'd0);
    send_byte(8'h3C);
    // finish mid-byte, then later bytes are ignored
    settle();
    write_reg(htwd_pkg::CFG_SYMBOL_COUNT, 32'd3);
    load_node(9'd256, 1'b1, 8'h00, 9'd0, 9'd511);
    send_byte(8'h00);
    send_byte(8'h55);
    // root moved to a leaf while the walk still sits on the old root
    settle();
    write_reg(htwd_pkg::CFG_SYMBOL_COUNT, 32'd5);
    load_node(9'd0, 1'b1, 8'hFF, 9'd511, 9'd511);
    settle();
    write_reg(htwd_pkg::CFG_ROOT_INDEX, 32'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    settle();
    write_reg(htwd_pkg::CFG_SYMBOL_COUNT, 32'd1);
    load_node(9'd511, 1'b0, 8'hC3, 9'd0, 9'd256);
    send_byte(8'h02);
    // zero count on a fresh message
    settle();
    write_reg(htwd_pkg::CFG_SYMBOL_COUNT, 32'd0);
    write_reg(htwd_pkg::CFG_ROOT_INDEX, 32'd511);
    load_node(9'd256, 1'b1, 8'h00, 9'd0, 9'd511);
    send_byte(8'hFF);

    msg = 0;
    while (item_cnt < 280) begin
      msg++;
      calm = (msg % 5 == 4);
      leaves = ($urandom_range(0, 9) == 0) ? 8 : int'($urandom_range(2, 5));
      tree_size = 2 * leaves - 1;
      for (int i = 0; i < tree_size; i++) begin
        do begin
          r = $urandom_range(0, 19);
          cand = (r == 0) ? 0 : (r == 1) ? 511 : int'($urandom_range(0, 511));
          dup = 1'b0;
          for (int m = 0; m < i; m++)
            if (tree_idx[m] == htwd_pkg::IdxW'(cand)) dup = 1'b1;
        end while (dup);
        tree_idx[i] = htwd_pkg::IdxW'(cand);
      end
      // grow the tree by splitting random leaves
      tree_leaf[0] = 1'b1;
      n = 1;
      while (n < tree_size) begin
        do p = $urandom_range(0, n - 1); while (!tree_leaf[p]);
        tree_leaf[p] = 1'b0;
        tree_zero[p] = n;
        tree_one[p] = n + 1;
        tree_leaf[n] = 1'b1;
        tree_leaf[n + 1] = 1'b1;
        n += 2;
      end
      // leaf children stay inside the tree so a leaf used as root is safe
      for (int i = 0; i < tree_size; i++) begin
        if (tree_leaf[i]) begin
          tree_zero[i] = $urandom_range(0, tree_size - 1);
          tree_one[i] = $urandom_range(0, tree_size - 1);
        end
      end

      settle();
      write_reg(htwd_pkg::CFG_ROOT_INDEX, 32'(tree_idx[0]));
      r = $urandom_range(0, 99);
      if (r < 8) lim = 32'd0;
      else if (r < 16) lim = 32'hFFFF_FFFF;
      else if (r < 24) lim = $urandom;
      else lim = $urandom_range(1, 24);
      if (msg == 3) lim = 32'hFFFF_FFFF;
      write_reg(htwd_pkg::CFG_SYMBOL_COUNT, lim);

      for (int i = 0; i < tree_size; i++) order[i] = i;
      for (int i = tree_size - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < tree_size; i++) begin
        k = order[i];
        load_node(tree_idx[k], tree_leaf[k], htwd_pkg::SymW'($urandom),
                  tree_idx[tree_zero[k]], tree_idx[tree_one[k]]);
      end

      if (msg == 3) begin
        calm = 1'b1;
        hold_req = 1'b1;
        nbytes = 16;
      end else begin
        nbytes = $urandom_range(3, 10);
      end
      for (int b = 0; b < nbytes; b++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // rewrite a node of this tree, which also restarts the message
          k = $urandom_range(0, tree_size - 1);
          load_node(tree_idx[k], 1'($urandom), htwd_pkg::SymW'($urandom),
                    tree_idx[$urandom_range(0, tree_size - 1)],
                    tree_idx[$urandom_range(0, tree_size - 1)]);
        end else if (r < 12) begin
          settle();
          if ($urandom_range(0, 1) == 1)
            write_reg(htwd_pkg::CFG_SYMBOL_COUNT, $urandom_range(0, 8));
          else
            write_reg(htwd_pkg::CFG_ROOT_INDEX,
                      32'(tree_idx[$urandom_range(0, tree_size - 1)]));
        end
        send_byte(htwd_pkg::SymW'($urandom));
      end
    end
    calm = 1'b0;

    settle();
    if (sb.mismatch_cnt == 0 && sb.expected_syms.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/htwd_pkg.sv
rtl/huffman_tree_walk_decoder_top.sv
tb/tb_huffman_tree_walk_decoder_top.sv
